### hw/rtl/rar_pkg.sv
package rar_pkg;

	localparam int OpW   = 16;
	localparam int MagW  = 33;
	localparam int NumW  = 33;
	localparam int DenW  = 31;
	localparam int QDepth = 2;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_OP   = 2'd1;
	localparam logic [1:0] ST_ZERO_DEN = 2'd2;

	typedef struct packed {
		logic [1:0]      req_type;
		logic [OpW-1:0]  a_numerator;
		logic [OpW-1:0]  a_denominator;
		logic [OpW-1:0]  b_numerator;
		logic [OpW-1:0]  b_denominator;
	} req_t;

	// unreduced job handed from front to back
	typedef struct packed {
		logic            n_neg;
		logic [MagW-1:0] n_mag;
		logic            d_neg;
		logic [MagW-1:0] d_mag;
	} job_t;

	typedef struct packed {
		logic [NumW-1:0] result_numerator;
		logic [DenW-1:0] result_denominator;
		logic [1:0]      status;
	} res_t;

endpackage

### hw/rtl/rar_front.sv
// Front: numerator cross products first, then the signed sum with the denominator product.
module rar_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rar_pkg::req_t in_req,
	output logic          job_valid,
	input  logic          job_ready,
	output rar_pkg::job_t job
);
	import rar_pkg::*;

	localparam int PW = 2 * OpW;

	logic                 busy_q;
	logic                 phase_q;
	logic                 done_q;
	req_t                 req_q;
	logic [OpW-1:0]       mag_an, mag_ad, mag_bn, mag_bd;
	logic                 sg_an, sg_ad, sg_bn, sg_bd;
	logic [PW-1:0]        p1_q, p2_q;
	logic                 s1_q, s2_q;
	logic [OpW-1:0]       m1x, m1y, m2x, m2y;
	logic                 m1s, m2s;
	logic [PW-1:0]        m1p, m2p;
	logic [MagW-1:0]      e1, e2, sum_mag;
	logic                 s2_eff, sum_neg;
	job_t                 job_q;

	function automatic logic [OpW-1:0] absv(input logic [OpW-1:0] v);
		return v[OpW-1] ? (~v + 1'b1) : v;
	endfunction

	assign sg_an = req_q.a_numerator[OpW-1];
	assign sg_ad = req_q.a_denominator[OpW-1];
	assign sg_bn = req_q.b_numerator[OpW-1];
	assign sg_bd = req_q.b_denominator[OpW-1];
	assign mag_an = absv(req_q.a_numerator);
	assign mag_ad = absv(req_q.a_denominator);
	assign mag_bn = absv(req_q.b_numerator);
	assign mag_bd = absv(req_q.b_denominator);

	// phase 0: numerator products; phase 1: denominator product
	always_comb begin
		m2x = mag_bn; m2y = mag_ad; m2s = sg_bn ^ sg_ad;
		if (!phase_q) begin
			if (req_q.req_type == OP_MUL) begin
				m1x = mag_an; m1y = mag_bn; m1s = sg_an ^ sg_bn;
			end else begin
				m1x = mag_an; m1y = mag_bd; m1s = sg_an ^ sg_bd;
			end
		end else begin
			if (req_q.req_type == OP_DIV) begin
				m1x = mag_ad; m1y = mag_bn; m1s = sg_ad ^ sg_bn;
			end else begin
				m1x = mag_ad; m1y = mag_bd; m1s = sg_ad ^ sg_bd;
			end
		end
	end
	assign m1p = m1x * m1y;
	assign m2p = m2x * m2y;

	assign e1 = MagW'(p1_q);
	assign e2 = MagW'(p2_q);
	always_comb begin
		s2_eff = (req_q.req_type == OP_SUB) ? ~s2_q : s2_q;
		if (req_q.req_type == OP_MUL || req_q.req_type == OP_DIV) begin
			sum_mag = e1; sum_neg = s1_q;
		end else if (s1_q == s2_eff) begin
			sum_mag = e1 + e2; sum_neg = s1_q;
		end else if (e1 >= e2) begin
			sum_mag = e1 - e2; sum_neg = s1_q;
		end else begin
			sum_mag = e2 - e1; sum_neg = s2_eff;
		end
		if (sum_mag == '0) sum_neg = 1'b0;
	end

	assign in_ready  = !busy_q;
	assign job_valid = done_q;
	assign job       = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
			end else if (busy_q && !done_q && !phase_q) begin
				phase_q <= 1'b1;
			end else if (busy_q && !done_q) begin
				done_q <= 1'b1;
			end else if (done_q && job_ready) begin
				done_q <= 1'b0;
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) req_q <= in_req;
		if (busy_q && !done_q && !phase_q) begin
			p1_q <= m1p; p2_q <= m2p;
			s1_q <= m1s && (m1p != '0);
			s2_q <= m2s && (m2p != '0);
		end
		if (busy_q && !done_q && phase_q) begin
			job_q.n_neg <= sum_neg;
			job_q.n_mag <= sum_mag;
			job_q.d_mag <= MagW'(m1p);
			job_q.d_neg <= m1s && (m1p != '0);
		end
	end

endmodule

### hw/rtl/rar_queue.sv
// Two-entry queue between front and back.
module rar_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  rar_pkg::job_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output rar_pkg::job_t rd_data
);
	import rar_pkg::*;

	job_t       mem_q [QDepth];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'(QDepth);
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

endmodule

### hw/rtl/rar_back.sv
// Back: Euclid by repeated restoring division, then two divisions by the gcd.
module rar_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  rar_pkg::job_t job,
	output logic          res_valid,
	input  logic          res_ready,
	output rar_pkg::res_t res
);
	import rar_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_GCD  = 3'd1;
	localparam logic [2:0] S_DN   = 3'd2;
	localparam logic [2:0] S_DD   = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;
	localparam int CW = $clog2(MagW + 1);

	logic [2:0]      state_q;
	job_t            job_q;
	logic [MagW-1:0] p_q, q_q;      // euclid operands
	logic [MagW-1:0] quo_q, rem_q, dvs_q, nq_q;
	logic [CW-1:0]   bit_q;
	logic            div_on_q;
	logic [MagW:0]   trial;
	logic [MagW-1:0] rem_sh;
	res_t            res_q;
	logic            neg;

	// one restoring step on quo_q (dividend shifting out), rem_q, dvs_q
	assign rem_sh = {rem_q[MagW-2:0], quo_q[MagW-1]};
	assign trial  = {rem_q, quo_q[MagW-1]} - {1'b0, dvs_q};
	assign neg    = job_q.n_neg ^ job_q.d_neg;

	assign job_ready = state_q == S_IDLE;
	assign res_valid = state_q == S_OUT;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (job_valid) begin
					if (job.d_mag == '0 || job.n_mag == '0) state_q <= S_OUT;
					else state_q <= S_GCD;
				end
				S_GCD: if (!div_on_q && q_q == '0) state_q <= S_DN;
				S_DN:  if (div_on_q && bit_q == '0) state_q <= S_DD;
				S_DD:  if (div_on_q && bit_q == '0) state_q <= S_OUT;
				S_OUT: if (res_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (div_on_q) begin
			quo_q <= {quo_q[MagW-2:0], ~trial[MagW]};
			rem_q <= trial[MagW] ? rem_sh : trial[MagW-1:0];
			bit_q <= bit_q - 1'b1;
			if (bit_q == '0) div_on_q <= 1'b0;
		end
		unique case (state_q)
			S_IDLE: begin
				div_on_q <= 1'b0;
				job_q <= job;
				p_q <= job.n_mag;
				q_q <= job.d_mag;
				if (job.d_mag == '0) begin
					res_q.result_numerator   <= NumW'(job.n_mag != '0);
					res_q.result_denominator <= '0;
					res_q.status             <= ST_ZERO_DEN;
				end else begin
					res_q.result_numerator   <= '0;
					res_q.result_denominator <= DenW'(1);
					res_q.status             <= ST_OK;
				end
			end
			S_GCD: begin
				if (!div_on_q && q_q != '0) begin
					quo_q <= p_q; rem_q <= '0; dvs_q <= q_q;
					bit_q <= CW'(MagW - 1); div_on_q <= 1'b1;
				end else if (div_on_q && bit_q == '0) begin
					p_q <= q_q;
					q_q <= trial[MagW] ? rem_sh : trial[MagW-1:0];
				end else if (!div_on_q) begin
					quo_q <= job_q.n_mag; rem_q <= '0; dvs_q <= p_q;
					bit_q <= CW'(MagW - 1); div_on_q <= 1'b1;
				end
			end
			S_DN: if (div_on_q && bit_q == '0) begin
				nq_q <= {quo_q[MagW-2:0], ~trial[MagW]};
			end
			S_DD: if (!div_on_q) begin
				quo_q <= job_q.d_mag; rem_q <= '0; dvs_q <= p_q;
				bit_q <= CW'(MagW - 1); div_on_q <= 1'b1;
			end else if (bit_q == '0) begin
				res_q.result_numerator <= neg ? NumW'(-nq_q) : NumW'(nq_q);
				res_q.result_denominator <= DenW'({quo_q[MagW-2:0], ~trial[MagW]});
				res_q.status <= ST_OK;
			end
			S_OUT: ;
			default: ;
		endcase
	end

endmodule

### hw/rtl/rational_arithmetic_reduce_unit.sv
// Channel | Dir | tdata (low bit up)                                | tuser
// s_axis  | in  | a_num[15:0] a_den[31:16] b_num[47:32] b_den[63:48] | req_type[1:0]
// m_axis  | out | result_numerator[32:0] result_denominator[63:33]   | status[1:0]
//
// One item at a time through the back end; the front starts the next item
// while the back runs. Each Euclid step and the two final divisions run in
// one shared bit-serial restoring divider, so the time per item grows with
// the Euclid step count. A zero unreduced numerator or denominator skips the
// divider. arst_n clears control state at once, but not the back's div_on_q.
// Stalls on m_axis hold the result; the queue lets the front accept until it fills.
module rational_arithmetic_reduce_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // a_numerator, a_denominator, b_numerator, b_denominator
	input  logic [1:0]  s_axis_tuser,   // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // result_numerator, result_denominator
	output logic [1:0]  m_axis_tuser    // status
);
	import rar_pkg::*;

	req_t req;
	job_t f_job, q_job;
	res_t res;
	logic f_valid, f_ready, q_valid, q_ready;

	// unpack the transfer into named fields
	assign req.req_type      = s_axis_tuser;
	assign req.a_numerator   = s_axis_tdata[15:0];
	assign req.a_denominator = s_axis_tdata[31:16];
	assign req.b_numerator   = s_axis_tdata[47:32];
	assign req.b_denominator = s_axis_tdata[63:48];

	rar_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(req),
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);

	rar_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
	);

	rar_back u_back (
		.clk, .arst_n,
		.job_valid(q_valid), .job_ready(q_ready), .job(q_job),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {res.result_denominator, res.result_numerator};
	assign m_axis_tuser = res.status;

	// a finished result never reports an invalid operation
	a_no_bad_op: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != ST_BAD_OP) else $error("bad status");
	// zero-denominator results carry a zero denominator field
	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == ST_ZERO_DEN) |-> m_axis_tdata[63:33] == '0)
		else $error("zero den mismatch");
	// ok results never have a zero denominator
	a_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == ST_OK) |-> m_axis_tdata[63:33] != '0)
		else $error("ok with zero den");

endmodule

### test/tb_rational_arithmetic_reduce_unit.sv
module tb_rational_arithmetic_reduce_unit;
	import rar_pkg::*;

	// one expected result per transfer on the input side
	typedef struct {
		logic [NumW-1:0] num;
		logic [DenW-1:0] den;
		logic [1:0]      status;
	} fraction_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;   // a_numerator, a_denominator, b_numerator, b_denominator
	logic [1:0]  s_axis_tuser;   // req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;   // result_numerator, result_denominator
	logic [1:0]  m_axis_tuser;   // status

	fraction_t   pending_fractions[$];
	int          error_count;
	int          idle_cycles;
	bit          rx_stall_enable;

	localparam int IdleLimit = 20000;

	rational_arithmetic_reduce_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Euclid on the magnitudes
	function automatic logic [63:0] gcd_of(logic [63:0] p, logic [63:0] q);
		logic [63:0] t;
		while (q != 0) begin
			t = p % q;
			p = q;
			q = t;
		end
		return p;
	endfunction

	// Work out the reduced fraction with signed 64-bit arithmetic; 16-bit
	// operands keep every product and sum well inside that range.
	function automatic fraction_t reduce_fraction(logic [1:0] op, logic [15:0] an,
			logic [15:0] ad, logic [15:0] bn, logic [15:0] bd);
		fraction_t   r;
		longint      n;
		longint      d;
		logic [63:0] nm;
		logic [63:0] dm;
		logic [63:0] g;
		logic        neg;
		case (op)
			OP_ADD: begin
				n = longint'($signed(an)) * $signed(bd) + longint'($signed(bn)) * $signed(ad);
				d = longint'($signed(ad)) * $signed(bd);
			end
			OP_SUB: begin
				n = longint'($signed(an)) * $signed(bd) - longint'($signed(bn)) * $signed(ad);
				d = longint'($signed(ad)) * $signed(bd);
			end
			OP_MUL: begin
				n = longint'($signed(an)) * $signed(bn);
				d = longint'($signed(ad)) * $signed(bd);
			end
			default: begin
				n = longint'($signed(an)) * $signed(bd);
				d = longint'($signed(ad)) * $signed(bn);
			end
		endcase
		r.status = ST_OK;
		if (d == 0) begin
			r.num    = (n != 0) ? 1 : 0;
			r.den    = 0;
			r.status = ST_ZERO_DEN;
		end else if (n == 0) begin
			r.num = 0;
			r.den = 1;
		end else begin
			neg = (n < 0) != (d < 0);
			nm  = (n < 0) ? -n : n;
			dm  = (d < 0) ? -d : d;
			g   = gcd_of(nm, dm);
			nm  = nm / g;
			dm  = dm / g;
			r.num = neg ? NumW'(-nm) : NumW'(nm);
			r.den = DenW'(dm);
		end
		return r;
	endfunction

	// Random gap: mostly zero or short, now and then long.
	function automatic int gap_len();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50)
			return 0;
		if (sel < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 300);
	endfunction

	// Valid stays high after the transfer so a following call can continue
	// back to back; callers drop it once their last item is sent.
	task automatic send_fraction_pair(logic [1:0] op, logic [15:0] an, logic [15:0] ad,
			logic [15:0] bn, logic [15:0] bd, bit with_gap);
		int gap;
		gap = with_gap ? gap_len() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {bd, bn, ad, an};
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		// record the expectation at the transfer edge
		pending_fractions.push_back(reduce_fraction(op, an, ad, bn, bd));
	endtask

	// Random operand, biased toward small magnitudes so Euclid stays short.
	function automatic logic [15:0] rand_operand();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return 16'($signed($urandom_range(0, 40)) - 20);
		if (sel < 6)
			return 16'(0);
		return 16'($urandom);
	endfunction

	task automatic wait_drained();
		while (pending_fractions.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed_extremes();
		send_fraction_pair(OP_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
		send_fraction_pair(OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0);
		send_fraction_pair(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
		send_fraction_pair(OP_DIV, 16'h8000, 16'hffff, 16'h7fff, 16'h0001, 0);
		send_fraction_pair(OP_ADD, 16'h0001, 16'h0003, 16'h0001, 16'h0006, 0);
		send_fraction_pair(OP_SUB, 16'h0001, 16'h0002, 16'h0001, 16'h0002, 0);
		send_fraction_pair(OP_MUL, 16'hfffd, 16'h0004, 16'h0008, 16'hfffa, 0);
		send_fraction_pair(OP_DIV, 16'h0005, 16'h0007, 16'hfff6, 16'h000e, 0);
		// zero numerator with a nonzero denominator reduces to 0/1
		send_fraction_pair(OP_MUL, 16'h0000, 16'h0005, 16'h0003, 16'h0007, 0);
		// zero unreduced denominator with a nonzero numerator gives 1/0
		send_fraction_pair(OP_ADD, 16'hfffb, 16'h0000, 16'h0003, 16'h0002, 0);
		send_fraction_pair(OP_DIV, 16'h0003, 16'h0004, 16'h0000, 16'h0005, 0);
		// zero unreduced denominator and zero numerator give 0/0
		send_fraction_pair(OP_MUL, 16'h0000, 16'h0000, 16'h0004, 16'h0001, 0);
		send_fraction_pair(OP_DIV, 16'h0000, 16'h0003, 16'h0000, 16'h0002, 0);
		// consecutive Fibonacci values give Euclid a long run
		send_fraction_pair(OP_MUL, 16'd28657, 16'd17711, 16'd1, 16'd1, 0);
		send_fraction_pair(OP_DIV, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 0);
		send_fraction_pair(OP_SUB, 16'hffff, 16'hffff, 16'h0001, 16'h0001, 0);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic test_drain_pause();
		// hold the sender until every expected result has come back
		wait_drained();
		send_fraction_pair(OP_ADD, rand_operand(), rand_operand(), rand_operand(),
			rand_operand(), 1);
		s_axis_tvalid <= 1'b0;
		wait_drained();
	endtask

	task automatic test_random_fractions(int count);
		for (int i = 0; i < count; i++) begin
			send_fraction_pair(2'($urandom), rand_operand(), rand_operand(),
				rand_operand(), rand_operand(), (i % 300) >= 100);
		end
		s_axis_tvalid <= 1'b0;
	endtask

	// Check each result transfer against the oldest expectation.
	always @(posedge clk) begin
		fraction_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_fractions.size() == 0) begin
				$error("result with nothing expected: %h/%h", m_axis_tdata, m_axis_tuser);
				error_count++;
			end else begin
				want = pending_fractions.pop_front();
				if (m_axis_tdata[NumW-1:0] !== want.num) begin
					$error("result_numerator: expected %h, got %h", want.num,
						m_axis_tdata[NumW-1:0]);
					error_count++;
				end
				if (m_axis_tdata[NumW+DenW-1:NumW] !== want.den) begin
					$error("result_denominator: expected %h, got %h", want.den,
						m_axis_tdata[NumW+DenW-1:NumW]);
					error_count++;
				end
				if (m_axis_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
					error_count++;
				end
			end
		end
	end

	// Random receiver stalls, with stretches of none.
	always @(posedge clk) begin
		if (!rx_stall_enable)
			m_axis_tready <= 1'b1;
		else
			m_axis_tready <= ($urandom_range(0, 99) < 65);
	end

	// Watchdog: count cycles without any transfer.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		s_axis_tvalid   = 1'b0;
		s_axis_tdata    = '0;
		s_axis_tuser    = '0;
		m_axis_tready   = 1'b0;
		error_count     = 0;
		idle_cycles     = 0;
		rx_stall_enable = 1'b0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		rx_stall_enable = 1'b1;
		test_drain_pause();
		test_random_fractions(900);
		rx_stall_enable = 1'b0;
		test_random_fractions(300);
		rx_stall_enable = 1'b1;
		test_random_fractions(600);
		wait_drained();
		repeat (1000)
			@(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/rar_pkg.sv
hw/rtl/rar_front.sv
hw/rtl/rar_queue.sv
hw/rtl/rar_back.sv
hw/rtl/rational_arithmetic_reduce_unit.sv
test/tb_rational_arithmetic_reduce_unit.sv
